[hdl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared widths, request codes and defaults for the set difference filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    // payload widths
    localparam int REQ_TYPE_W = 2;
    localparam int VALUE_W    = 16;
    localparam int COUNT_W    = 16;

    // default depth of the exclusion set
    localparam int SET_DEPTH_DEF = 256;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_TEST  = 2'd2;

    // saturation point of the missing count
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

`default_nettype wire

[hdl/sdf_if.sv]
// ----------------------------------------------------------------------------
// sdf_req_if / sdf_res_if
// Valid/ready channels for requests into and results out of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_req_if;
    logic                             valid;
    logic                             ready;
    logic [sdf_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [sdf_pkg::VALUE_W-1:0]      value;
    logic                             final_item;

    modport source (output valid, output req_type, output value, output final_item,
                    input ready);
    modport sink   (input valid, input req_type, input value, input final_item,
                    output ready);
endinterface

interface sdf_res_if;
    logic                          valid;
    logic                          ready;
    logic [sdf_pkg::VALUE_W-1:0]   value_out;
    logic                          is_missing;
    logic [sdf_pkg::COUNT_W-1:0]   missing_count;
    logic                          last;
    logic                          set_overflowed;

    modport source (output valid, output value_out, output is_missing,
                    output missing_count, output last, output set_overflowed,
                    input ready);
    modport sink   (input valid, input value_out, input is_missing,
                    input missing_count, input last, input set_overflowed,
                    output ready);
endinterface

`default_nettype wire

[hdl/set_difference_filter_unit.sv]
// ----------------------------------------------------------------------------
// set_difference_filter_unit
// Exclusion set in a RAM, searched linearly for each tested candidate.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | req_type, value, final_item
//  res     | out | valid/ready  | value_out, is_missing, missing_count, last,
//          |     |              | set_overflowed
//
//  clear and add are taken in idle; req stays ready afterwards
//  a test holds req not ready until its result is loaded: the store has
//  one read port and is compared one entry per cycle, stopping at a match
//  the result sits in an output register; a stalled res only blocks the end
//  of the next test, clear and add still go through
//  rst_n empties the set and zeroes the count and overflow flag; store
//  contents are not cleared, only entries below the fill count are read
// ----------------------------------------------------------------------------
`default_nettype none

module set_difference_filter_unit #(
    parameter int SET_DEPTH = sdf_pkg::SET_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sdf_req_if.sink    req,
    sdf_res_if.source  res
);

    localparam int CNT_W  = $clog2(SET_DEPTH + 1);
    localparam int ADDR_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                set_count_reg, set_count_next;
    logic [CNT_W-1:0]                issue_reg, issue_next;
    logic                            pend_reg, pend_next;
    logic                            miss_reg, miss_next;
    logic                            ovf_reg, ovf_next;
    logic [sdf_pkg::COUNT_W-1:0]     total_reg, total_next;
    logic [sdf_pkg::VALUE_W-1:0]     cand_reg;
    logic                            fin_reg;
    logic                            res_valid_reg, res_valid_next;
    logic [sdf_pkg::VALUE_W-1:0]     res_value_reg;
    logic                            res_miss_reg;
    logic [sdf_pkg::COUNT_W-1:0]     res_count_reg;
    logic                            res_last_reg;
    logic                            res_ovf_reg;

    logic                            req_xfer;
    logic                            ram_we;
    logic                            ram_re;
    logic [sdf_pkg::VALUE_W-1:0]     ram_rdata;
    logic                            hit;
    logic                            res_load;
    logic [sdf_pkg::COUNT_W-1:0]     total_inc;

    // store for the exclusion set
    sdf_ram #(
        .WIDTH (sdf_pkg::VALUE_W),
        .DEPTH (SET_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_count_reg[ADDR_W-1:0]),
        .wdata (req.value),
        .re    (ram_re),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // handshake and compare
    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign ram_we    = req_xfer && (req.req_type == sdf_pkg::REQ_ADD)
                       && (set_count_reg < DEPTH_C);
    assign ram_re    = (state_reg == ST_SEARCH) && (issue_reg < set_count_reg);
    assign hit       = pend_reg && (ram_rdata == cand_reg);
    assign res_load  = (state_reg == ST_FINISH) && (!res_valid_reg || res.ready);
    assign total_inc = (miss_reg && (total_reg != sdf_pkg::COUNT_MAX))
                       ? total_reg + 1'b1 : total_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        set_count_next = set_count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        miss_next      = miss_reg;
        ovf_next       = ovf_reg;
        total_next     = total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                issue_next = '0;
                if (req_xfer)
                begin
                    unique case (req.req_type)
                        sdf_pkg::REQ_CLEAR:
                        begin
                            set_count_next = '0;
                            total_next     = '0;
                            ovf_next       = 1'b0;
                        end
                        sdf_pkg::REQ_ADD:
                        begin
                            if (set_count_reg < DEPTH_C)
                            begin
                                set_count_next = set_count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        sdf_pkg::REQ_TEST:
                        begin
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    miss_next  = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (!ram_re && !pend_reg)
                begin
                    miss_next  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    pend_next = ram_re;
                    if (ram_re)
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_load)
                begin
                    total_next = total_inc;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_count_reg <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            miss_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            set_count_reg <= set_count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            miss_reg      <= miss_next;
            ovf_reg       <= ovf_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // candidate capture on transfer
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            cand_reg <= req.value;
            fin_reg  <= req.final_item;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_value_reg <= cand_reg;
            res_miss_reg  <= miss_reg;
            res_count_reg <= total_inc;
            res_last_reg  <= fin_reg;
            res_ovf_reg   <= ovf_reg;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.value_out      = res_value_reg;
    assign res.is_missing     = res_miss_reg;
    assign res.missing_count  = res_count_reg;
    assign res.last           = res_last_reg;
    assign res.set_overflowed = res_ovf_reg;

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        set_count_reg <= DEPTH_C)
        else $error("set count beyond depth");

    // an add to a full set raises the overflow flag
    a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.req_type == sdf_pkg::REQ_ADD) && (set_count_reg == DEPTH_C))
        |=> ovf_reg)
        else $error("overflow flag not set on dropped add");

    // a found candidate leaves the running count unchanged
    a_found_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !miss_reg) |=> (total_reg == $past(total_reg)))
        else $error("count moved on found candidate");

    // a missing result never reports a zero count
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.is_missing) |-> (res.missing_count != '0))
        else $error("missing result with zero count");

    // pending read data only follows an issued read
    a_pend_issue: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (issue_reg != '0))
        else $error("read data pending without issued read");

endmodule

`default_nettype wire

[hdl/sdf_ram.sv]
// ----------------------------------------------------------------------------
// sdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ram #(
    parameter int WIDTH = sdf_pkg::VALUE_W,
    parameter int DEPTH = sdf_pkg::SET_DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
